// ===== rtl/dc_motor_opto_position_seek_core_defines.svh =====
// Assertion macros shared by the motor seek core.
`ifndef DC_MOTOR_OPTO_POSITION_SEEK_CORE_DEFINES_SVH
`define DC_MOTOR_OPTO_POSITION_SEEK_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DMOPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DMOPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dmops_pkg.sv =====
// Types and constants for the motor seek core.
package dmops_pkg;

  typedef enum logic [2:0] {
    OP_VERSION  = 3'd0,
    OP_FORWARD  = 3'd1,
    OP_REVERSE  = 3'd2,
    OP_SET_POS  = 3'd3,
    OP_READ_POS = 3'd4,
    OP_SEEK     = 3'd5,
    OP_PERIOD   = 3'd6,
    OP_PRESCALE = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    REPLY_NONE     = 2'd0,
    REPLY_VERSION  = 2'd1,
    REPLY_POSITION = 2'd2
  } reply_kind_t;

  localparam logic       KIND_COMMAND = 1'b0;
  localparam logic [7:0] VERSION_LOW  = 8'd0;
  localparam logic [7:0] VERSION_HIGH = 8'd1;
  localparam logic [7:0] FULL_SPEED   = 8'd255;
  localparam logic [7:0] PERIOD_RESET = 8'd255;

  typedef struct packed {
    logic       kind;
    opcode_t    opcode;
    logic [7:0] arg_one;
    logic [7:0] arg_two;
    logic [7:0] arg_three;
    logic       marker;
  } item_t;

  typedef struct packed {
    logic [15:0] position;
    logic [15:0] target;
    logic        seek_active;
    logic        reverse_dir;
    logic        last_marker;
    logic [7:0]  period_setting;
    logic [7:0]  duty;
    logic [7:0]  period;
    logic [1:0]  prescale;
    logic [1:0]  enables;
  } state_t;

  typedef struct packed {
    logic        forward_enable;
    logic        reverse_enable;
    logic [7:0]  duty;
    logic [7:0]  period;
    logic [1:0]  prescale;
    reply_kind_t reply_kind;
    logic [7:0]  reply_low;
    logic [7:0]  reply_high;
    logic [15:0] position;
  } result_t;

  localparam state_t STATE_RESET = '{
    position:       16'd0,
    target:         16'd0,
    seek_active:    1'b0,
    reverse_dir:    1'b0,
    last_marker:    1'b0,
    period_setting: PERIOD_RESET,
    duty:           8'd0,
    period:         PERIOD_RESET,
    prescale:       2'd0,
    enables:        2'd0
  };

endpackage

// ===== rtl/dc_motor_opto_position_seek_core.sv =====
// Throughput: one item per cycle while results are not stalled; input register,
// one pass of step logic, result register.
// The motor state updates as an item moves from the input register to the result register.
// A stalled result holds the input register, which then stalls the item channel.
// Reset (synchronous, active high) clears the position, ends any seek, turns the drive
// off, sets both period values to 255 and empties both registers.
`include "dc_motor_opto_position_seek_core_defines.svh"

module dc_motor_opto_position_seek_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               kind,
  input  logic [2:0]         opcode,
  input  logic [7:0]         arg_one,
  input  logic [7:0]         arg_two,
  input  logic [7:0]         arg_three,
  input  logic               marker,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               forward_enable,
  output logic               reverse_enable,
  output logic [7:0]         duty,
  output logic [7:0]         period,
  output logic [1:0]         prescale,
  output logic [1:0]         reply_kind,
  output logic [7:0]         reply_low,
  output logic [7:0]         reply_high,
  output logic signed [15:0] position
);

  logic                full;
  logic                advance;
  dmops_pkg::item_t    item;
  dmops_pkg::state_t   state;
  dmops_pkg::state_t   state_next;
  dmops_pkg::result_t  step_result;
  dmops_pkg::result_t  result;

  // An item moves on when the result register is empty or being emptied.
  assign advance = full && (!result_valid || !result_stall);

  dmops_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .opcode     (opcode),
    .arg_one    (arg_one),
    .arg_two    (arg_two),
    .arg_three  (arg_three),
    .marker     (marker),
    .advance    (advance),
    .full       (full),
    .item       (item)
  );

  dmops_step u_step (
    .item       (item),
    .state      (state),
    .state_next (state_next),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmops_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign forward_enable = result.forward_enable;
  assign reverse_enable = result.reverse_enable;
  assign duty           = result.duty;
  assign period         = result.period;
  assign prescale       = result.prescale;
  assign reply_kind     = result.reply_kind;
  assign reply_low      = result.reply_low;
  assign reply_high     = result.reply_high;
  assign position       = $signed(result.position);

  `DMOPS_ASSERT_NOW(a_no_reply_zero, clk, rst, result_valid && (reply_kind == dmops_pkg::REPLY_NONE), (reply_low == 8'd0) && (reply_high == 8'd0), "reply bytes set without a reply")
  `DMOPS_ASSERT_NEXT(a_state_holds, clk, rst, !advance, $stable(state), "motor state changed without a transfer")
  `DMOPS_ASSERT_NEXT(a_stall_keeps_item, clk, rst, full && result_valid && result_stall, full, "input register emptied while result stalled")
  `DMOPS_ASSERT_NOW(a_result_matches_state, clk, rst, result_valid, result.position == state.position, "result position differs from stored position")

endmodule

// ===== rtl/dmops_in_stage.sv =====
// Input register stage with valid/stall handshake.
module dmops_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 kind,
  input  logic [2:0]           opcode,
  input  logic [7:0]           arg_one,
  input  logic [7:0]           arg_two,
  input  logic [7:0]           arg_three,
  input  logic                 marker,
  input  logic                 advance,
  output logic                 full,
  output dmops_pkg::item_t     item
);

  logic accept;

  // The stage frees up in the same cycle that its item moves on.
  assign item_stall = full && !advance;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind      <= kind;
      item.opcode    <= dmops_pkg::opcode_t'(opcode);
      item.arg_one   <= arg_one;
      item.arg_two   <= arg_two;
      item.arg_three <= arg_three;
      item.marker    <= marker;
    end
  end

endmodule

// ===== rtl/dmops_step.sv =====
// Next-state and result logic for one command or marker sample.
module dmops_step (
  input  dmops_pkg::item_t   item,
  input  dmops_pkg::state_t  state,
  output dmops_pkg::state_t  state_next,
  output dmops_pkg::result_t result
);

  // Apply a speed and direction to the drive fields.
  function automatic dmops_pkg::state_t drive(input dmops_pkg::state_t s,
                                              input logic [7:0] speed,
                                              input logic dir);
    dmops_pkg::state_t r;
    r = s;
    if (speed == 8'd0) begin
      r.enables = 2'b00;
    end else begin
      r.enables = dir ? 2'b10 : 2'b01;
    end
    r.duty        = speed;
    r.period      = (speed == dmops_pkg::FULL_SPEED) ? 8'd0 : s.period_setting;
    r.reverse_dir = dir;
    return r;
  endfunction

  dmops_pkg::reply_kind_t reply_kind;
  logic [7:0]             reply_low;
  logic [7:0]             reply_high;
  logic [15:0]            stepped;
  logic [15:0]            seek_target;

  assign stepped     = state.reverse_dir ? (state.position - 16'd1)
                                         : (state.position + 16'd1);
  assign seek_target = {item.arg_three, item.arg_two};

  always_comb begin
    state_next = state;
    reply_kind = dmops_pkg::REPLY_NONE;
    reply_low  = 8'd0;
    reply_high = 8'd0;
    if (item.kind != dmops_pkg::KIND_COMMAND) begin
      if (item.marker && !state.last_marker) begin
        state_next.position = stepped;
        // Reaching the target ends the seek and stops the motor.
        if (state.seek_active && (stepped == state.target)) begin
          state_next.seek_active = 1'b0;
          state_next.enables     = 2'b00;
          state_next.duty        = 8'd0;
        end
      end
      state_next.last_marker = item.marker;
    end else begin
      case (item.opcode)
        dmops_pkg::OP_VERSION: begin
          reply_kind = dmops_pkg::REPLY_VERSION;
          reply_low  = dmops_pkg::VERSION_LOW;
          reply_high = dmops_pkg::VERSION_HIGH;
        end
        dmops_pkg::OP_FORWARD: begin
          state_next = drive(state, item.arg_one, 1'b0);
        end
        dmops_pkg::OP_REVERSE: begin
          state_next = drive(state, item.arg_one, 1'b1);
        end
        dmops_pkg::OP_SET_POS: begin
          state_next.position = {item.arg_two, item.arg_one};
        end
        dmops_pkg::OP_READ_POS: begin
          reply_kind = dmops_pkg::REPLY_POSITION;
          reply_low  = state.position[7:0];
          reply_high = state.position[15:8];
        end
        dmops_pkg::OP_SEEK: begin
          // A seek to the current position only loads the target.
          if (seek_target != state.position) begin
            state_next = drive(state, item.arg_one,
                               $signed(state.position) > $signed(seek_target));
            state_next.seek_active = (item.arg_one != 8'd0);
          end
          state_next.target = seek_target;
        end
        dmops_pkg::OP_PERIOD: begin
          state_next.period_setting = item.arg_one;
          state_next.period         = item.arg_one;
        end
        dmops_pkg::OP_PRESCALE: begin
          state_next.prescale = item.arg_one[1:0];
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  always_comb begin
    result.forward_enable = state_next.enables[0];
    result.reverse_enable = state_next.enables[1];
    result.duty           = state_next.duty;
    result.period         = state_next.period;
    result.prescale       = state_next.prescale;
    result.reply_kind     = reply_kind;
    result.reply_low      = reply_low;
    result.reply_high     = reply_high;
    result.position       = state_next.position;
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the DC motor opto position seek core.
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT  = 1000;
  localparam int ITEM_TARGET  = 1300;
  localparam int HOLD_CYCLES  = 90;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_CYCLES = 8;

  // Tracks the motor state from accepted transfers and checks each result against it.
  class motor_status_board;
    logic [15:0] count_pos;
    logic [15:0] goal_pos;
    logic [7:0]  seek_rate;
    logic        rev_dir;
    logic        prev_marker;
    logic [7:0]  base_period;
    logic [7:0]  duty_now;
    logic [7:0]  period_now;
    logic [1:0]  prescale_now;
    logic [1:0]  drive_en;
    dmops_pkg::result_t pending_status[$];
    int          errors;
    int          checked;
    int          commands;
    int          markers;
    int          seeks_reached;

    function new();
      count_pos    = 16'd0;
      goal_pos     = 16'd0;
      seek_rate    = 8'd0;
      rev_dir      = 1'b0;
      prev_marker  = 1'b0;
      base_period  = dmops_pkg::PERIOD_RESET;
      duty_now     = 8'd0;
      period_now   = dmops_pkg::PERIOD_RESET;
      prescale_now = 2'd0;
      drive_en     = 2'd0;
      errors       = 0;
      checked      = 0;
      commands     = 0;
      markers      = 0;
      seeks_reached = 0;
    endfunction

    function void apply_speed(input logic [7:0] rate, input logic dir);
      if (rate == 8'd0) drive_en = 2'b00;
      else drive_en = dir ? 2'b10 : 2'b01;
      duty_now   = rate;
      period_now = (rate == dmops_pkg::FULL_SPEED) ? 8'd0 : base_period;
      rev_dir    = dir;
    endfunction

    task note_item(input logic k, input dmops_pkg::opcode_t op, input logic [7:0] a1,
                   input logic [7:0] a2, input logic [7:0] a3, input logic mk);
      dmops_pkg::result_t r;
      r.reply_kind = dmops_pkg::REPLY_NONE;
      r.reply_low  = 8'd0;
      r.reply_high = 8'd0;
      if (k != dmops_pkg::KIND_COMMAND) begin
        markers++;
        if (mk && !prev_marker) begin
          count_pos = rev_dir ? count_pos - 16'd1 : count_pos + 16'd1;
          if (seek_rate != 8'd0 && count_pos == goal_pos) begin
            seek_rate = 8'd0;
            drive_en  = 2'b00;
            duty_now  = 8'd0;
            seeks_reached++;
          end
        end
        prev_marker = mk;
      end else begin
        commands++;
        case (op)
          dmops_pkg::OP_VERSION: begin
            r.reply_kind = dmops_pkg::REPLY_VERSION;
            r.reply_low  = dmops_pkg::VERSION_LOW;
            r.reply_high = dmops_pkg::VERSION_HIGH;
          end
          dmops_pkg::OP_FORWARD: apply_speed(a1, 1'b0);
          dmops_pkg::OP_REVERSE: apply_speed(a1, 1'b1);
          dmops_pkg::OP_SET_POS: count_pos = {a2, a1};
          dmops_pkg::OP_READ_POS: begin
            r.reply_kind = dmops_pkg::REPLY_POSITION;
            r.reply_low  = count_pos[7:0];
            r.reply_high = count_pos[15:8];
          end
          dmops_pkg::OP_SEEK: begin
            goal_pos = {a3, a2};
            // Seeking to where the motor already is only loads the target.
            if (goal_pos != count_pos) begin
              seek_rate = a1;
              apply_speed(a1, $signed(count_pos) > $signed(goal_pos));
            end
          end
          dmops_pkg::OP_PERIOD: begin
            base_period = a1;
            period_now  = a1;
          end
          dmops_pkg::OP_PRESCALE: prescale_now = a1[1:0];
          default: begin
          end
        endcase
      end
      r.forward_enable = drive_en[0];
      r.reverse_enable = drive_en[1];
      r.duty           = duty_now;
      r.period         = period_now;
      r.prescale       = prescale_now;
      r.position       = count_pos;
      pending_status.push_back(r);
    endtask

    task report(input string what, input logic [15:0] got, input logic [15:0] want);
      errors++;
      $display("%0t: mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
               $time, what, checked, got, want);
    endtask

    task check_result(input dmops_pkg::result_t got);
      dmops_pkg::result_t want;
      if (pending_status.size() == 0) begin
        report("result with nothing pending", got.position, 16'd0);
        return;
      end
      want = pending_status.pop_front();
      if (got.forward_enable !== want.forward_enable)
        report("forward_enable", 16'(got.forward_enable), 16'(want.forward_enable));
      if (got.reverse_enable !== want.reverse_enable)
        report("reverse_enable", 16'(got.reverse_enable), 16'(want.reverse_enable));
      if (got.duty !== want.duty) report("duty", 16'(got.duty), 16'(want.duty));
      if (got.period !== want.period) report("period", 16'(got.period), 16'(want.period));
      if (got.prescale !== want.prescale)
        report("prescale", 16'(got.prescale), 16'(want.prescale));
      if (got.reply_kind !== want.reply_kind)
        report("reply_kind", 16'(got.reply_kind), 16'(want.reply_kind));
      if (got.reply_low !== want.reply_low)
        report("reply_low", 16'(got.reply_low), 16'(want.reply_low));
      if (got.reply_high !== want.reply_high)
        report("reply_high", 16'(got.reply_high), 16'(want.reply_high));
      if (got.position !== want.position) report("position", got.position, want.position);
      checked++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic               kind = 1'b0;
  logic [2:0]         opcode = 3'd0;
  logic [7:0]         arg_one = 8'd0;
  logic [7:0]         arg_two = 8'd0;
  logic [7:0]         arg_three = 8'd0;
  logic               marker = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               forward_enable;
  logic               reverse_enable;
  logic [7:0]         duty;
  logic [7:0]         period;
  logic [1:0]         prescale;
  logic [1:0]         reply_kind;
  logic [7:0]         reply_low;
  logic [7:0]         reply_high;
  logic signed [15:0] position;

  motor_status_board board;
  bit                send_calm = 1'b0;
  int                items_sent = 0;

  dc_motor_opto_position_seek_core dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .kind           (kind),
    .opcode         (opcode),
    .arg_one        (arg_one),
    .arg_two        (arg_two),
    .arg_three      (arg_three),
    .marker         (marker),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .forward_enable (forward_enable),
    .reverse_enable (reverse_enable),
    .duty           (duty),
    .period         (period),
    .prescale       (prescale),
    .reply_kind     (reply_kind),
    .reply_low      (reply_low),
    .reply_high     (reply_high),
    .position       (position)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Calm stretches have no idle cycles at all; otherwise mostly short waits.
  function automatic int pick_wait(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(1, 3);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [15:0] pick_position();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF - 16'($urandom_range(0, 5));
      1: return 16'h8000 + 16'($urandom_range(0, 5));
      2: return 16'($urandom_range(0, 5));
      3: return 16'hFFFF - 16'($urandom_range(0, 5));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic k, input dmops_pkg::opcode_t op,
                           input logic [7:0] a1, input logic [7:0] a2,
                           input logic [7:0] a3, input logic mk);
    int gap;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = pick_wait(send_calm);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    opcode     <= op;
    arg_one    <= a1;
    arg_two    <= a2;
    arg_three  <= a3;
    marker     <= mk;
    do @(posedge clk); while (item_stall);
    board.note_item(k, op, a1, a2, a3, mk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_command(input dmops_pkg::opcode_t op, input logic [7:0] a1,
                              input logic [7:0] a2, input logic [7:0] a3);
    send_item(dmops_pkg::KIND_COMMAND, op, a1, a2, a3, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_marker(input logic mk);
    send_item(~dmops_pkg::KIND_COMMAND, dmops_pkg::opcode_t'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), mk);
  endtask

  task automatic random_command();
    send_command(dmops_pkg::opcode_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  initial begin : result_side
    int n;
    bit calm;
    bit held;
    calm = 1'b0;
    held = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) calm = !calm;
      // One long hold-off lets the core fill up and push back on the item side.
      if (!held && board.checked >= HOLD_AFTER) begin
        n = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        n = pick_wait(calm);
      end
      if (n != 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!result_valid);
      board.check_result('{forward_enable, reverse_enable, duty, period, prescale,
                           dmops_pkg::reply_kind_t'(reply_kind), reply_low, reply_high,
                           position});
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles, giving up", $time, QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] tgt;
    logic [15:0] base;
    logic [7:0]  rate;
    int          delta;
    int          steps;
    board = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: replies, period and prescale extremes, wrap both ways and seeks.
    send_item(dmops_pkg::KIND_COMMAND, dmops_pkg::OP_VERSION, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_command(dmops_pkg::OP_PERIOD, 8'h00, 8'h00, 8'h00);
    send_command(dmops_pkg::OP_FORWARD, dmops_pkg::FULL_SPEED, 8'h00, 8'h00);
    send_command(dmops_pkg::OP_PRESCALE, 8'hFF, 8'hFF, 8'hFF);
    send_command(dmops_pkg::OP_FORWARD, 8'h00, 8'hFF, 8'h00);
    send_command(dmops_pkg::OP_SET_POS, 8'hFF, 8'h7F, 8'h00);
    send_command(dmops_pkg::OP_FORWARD, 8'd100, 8'h00, 8'h00);
    send_item(~dmops_pkg::KIND_COMMAND, dmops_pkg::OP_PRESCALE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_marker(1'b0);
    send_command(dmops_pkg::OP_REVERSE, 8'h01, 8'h00, 8'h00);
    send_marker(1'b1);
    send_marker(1'b0);
    send_command(dmops_pkg::OP_READ_POS, 8'h00, 8'h00, 8'h00);
    send_command(dmops_pkg::OP_SEEK, 8'd50, 8'hFF, 8'h7F);
    send_command(dmops_pkg::OP_SEEK, 8'h00, 8'h00, 8'h00);
    send_command(dmops_pkg::OP_SET_POS, 8'h00, 8'h00, 8'h00);
    send_command(dmops_pkg::OP_SEEK, 8'd80, 8'h02, 8'h00);
    send_marker(1'b1);
    send_marker(1'b0);
    send_marker(1'b1);
    send_marker(1'b0);
    send_command(dmops_pkg::OP_SEEK, dmops_pkg::FULL_SPEED, 8'h00, 8'h00);
    send_marker(1'b1);
    send_marker(1'b0);
    send_marker(1'b1);

    // Random part: half the rounds are seeks toward nearby targets driven by marker pulses.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if ($urandom_range(0, 2) == 0) begin
            base = pick_position();
            send_command(dmops_pkg::OP_SET_POS, base[7:0], base[15:8],
                         8'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 3) == 0)
            send_command(dmops_pkg::OP_PERIOD, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          case ($urandom_range(0, 7))
            0: rate = 8'd0;
            1: rate = dmops_pkg::FULL_SPEED;
            default: rate = 8'($urandom_range(1, 254));
          endcase
          delta = int'($urandom_range(0, 12)) - 6;
          tgt = board.count_pos + delta[15:0];
          send_command(dmops_pkg::OP_SEEK, rate, tgt[7:0], tgt[15:8]);
          steps = $urandom_range(0, 9);
          repeat (steps) begin
            send_marker(1'b1);
            send_marker(1'b0);
            if ($urandom_range(0, 5) == 0) random_command();
          end
          if ($urandom_range(0, 1) == 0)
            send_command(dmops_pkg::OP_READ_POS, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        5, 6: random_command();
        default: begin
          repeat ($urandom_range(1, 4)) send_marker(1'($urandom_range(0, 1)));
        end
      endcase
    end
    item_valid <= 1'b0;

    while (board.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending_status.size() != 0)
      board.report("results never seen", 16'(board.pending_status.size()), 16'd0);

    $display("Sent %0d commands and %0d marker samples; %0d results checked.",
             board.commands, board.markers, board.checked);
    $display("Seeks that reached their target: %0d; mismatches: %0d.",
             board.seeks_reached, board.errors);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
